// ===== design/tcpk_pkg.sv =====
package tcpk_pkg;

  localparam int unsigned CoordBits   = 21;
  localparam int unsigned OutBits     = CoordBits + 1;
  localparam int unsigned SpacingBits = 20;
  localparam logic [SpacingBits-1:0] SpacingReset = 20'd256000;

  // squares and their sums are below 2^43
  localparam int unsigned SqBits     = 2 * CoordBits + 1;
  localparam int unsigned ProdBits   = 2 * CoordBits;
  localparam int unsigned DenBits    = SpacingBits + 1;
  localparam int unsigned DivStages  = SqBits;
  localparam int unsigned RootBits   = OutBits;
  localparam int unsigned SqrtStages = RootBits;
  localparam int unsigned FrontStages = 4;
  localparam int unsigned MidStages   = 2;
  localparam int unsigned Latency = FrontStages + DivStages + MidStages + SqrtStages + 1;

  typedef enum logic {
    OP_INVERSE = 1'b0,
    OP_FORWARD = 1'b1
  } tcpk_op_e;

  typedef struct packed {
    tcpk_op_e               op;
    logic                   neg;
    logic                   zero;
    logic                   mid;
    logic [SpacingBits-1:0] d;
    logic [CoordBits-1:0]   l1;
    logic [ProdBits-1:0]    l1sq;
    logic [SqBits-1:0]      ra;
    logic [SqBits-1:0]      rb;
  } tcpk_div_side_t;

  typedef struct packed {
    tcpk_op_e           op;
    logic               noy;
    logic               flag;
    logic [OutBits-1:0] ox;
  } tcpk_sq_side_t;

endpackage

// ===== design/tcpk_div.sv =====
// Restoring divider, one quotient bit per stage, sideband carried along.
module tcpk_div (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                valid_i,
  input  logic [tcpk_pkg::SqBits-1:0]         num_i,
  input  logic [tcpk_pkg::DenBits-1:0]        den_i,
  input  tcpk_pkg::tcpk_div_side_t            side_i,
  output logic                                valid_o,
  output logic [tcpk_pkg::SqBits-1:0]         quo_o,
  output tcpk_pkg::tcpk_div_side_t            side_o
);

  localparam int unsigned NumW = tcpk_pkg::SqBits;
  localparam int unsigned DenW = tcpk_pkg::DenBits;
  localparam int unsigned Nst  = tcpk_pkg::DivStages;

  logic [Nst-1:0]           vld_q;
  logic [NumW-1:0]          num_q  [Nst];
  logic [DenW-1:0]          rem_q  [Nst];
  logic [DenW-1:0]          den_q  [Nst];
  tcpk_pkg::tcpk_div_side_t side_q [Nst];

  for (genvar k = 0; k < Nst; k++) begin : g_st
    logic                     vld_in;
    logic [NumW-1:0]          num_in;
    logic [DenW-1:0]          rem_in;
    logic [DenW-1:0]          den_in;
    tcpk_pkg::tcpk_div_side_t side_in;
    logic [DenW:0]            trial;
    logic [DenW:0]            diff;
    logic                     ge;

    if (k == 0) begin : g_first
      assign vld_in  = valid_i;
      assign num_in  = num_i;
      assign rem_in  = '0;
      assign den_in  = den_i;
      assign side_in = side_i;
    end else begin : g_next
      assign vld_in  = vld_q[k-1];
      assign num_in  = num_q[k-1];
      assign rem_in  = rem_q[k-1];
      assign den_in  = den_q[k-1];
      assign side_in = side_q[k-1];
    end

    // bring down the next dividend bit, subtract when it fits
    assign trial = {rem_in, num_in[NumW-1]};
    assign ge    = trial >= {1'b0, den_in};
    assign diff  = trial - {1'b0, den_in};

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[k] <= 1'b0;
      end else begin
        vld_q[k] <= vld_in;
      end
    end

    always_ff @(posedge clk_i) begin
      num_q[k]  <= {num_in[NumW-2:0], ge};
      rem_q[k]  <= ge ? diff[DenW-1:0] : trial[DenW-1:0];
      den_q[k]  <= den_in;
      side_q[k] <= side_in;
    end
  end

  assign valid_o = vld_q[Nst-1];
  assign quo_o   = num_q[Nst-1];
  assign side_o  = side_q[Nst-1];

endmodule

// ===== design/tcpk_sqrt.sv =====
// Two-lane floor square root, two radicand bits per stage.
module tcpk_sqrt (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          valid_i,
  input  logic [tcpk_pkg::SqBits-1:0]   rad_a_i,
  input  logic [tcpk_pkg::SqBits-1:0]   rad_b_i,
  input  tcpk_pkg::tcpk_sq_side_t       side_i,
  output logic                          valid_o,
  output logic [tcpk_pkg::RootBits-1:0] root_a_o,
  output logic [tcpk_pkg::RootBits-1:0] root_b_o,
  output tcpk_pkg::tcpk_sq_side_t       side_o
);

  localparam int unsigned RtW  = tcpk_pkg::RootBits;
  localparam int unsigned RadW = 2 * RtW;
  localparam int unsigned RemW = RtW + 1;
  localparam int unsigned Nst  = tcpk_pkg::SqrtStages;

  typedef struct packed {
    logic [RadW-1:0] rad;
    logic [RemW-1:0] rem;
    logic [RtW-1:0]  root;
  } lane_t;

  function automatic lane_t sq_step(lane_t s);
    logic [RemW+1:0] cur;
    logic [RemW+1:0] trial;
    lane_t           n;
    cur   = {s.rem, s.rad[RadW-1:RadW-2]};
    trial = {1'b0, s.root, 2'b01};
    n.rad = {s.rad[RadW-3:0], 2'b00};
    if (cur >= trial) begin
      n.rem  = RemW'(cur - trial);
      n.root = {s.root[RtW-2:0], 1'b1};
    end else begin
      n.rem  = cur[RemW-1:0];
      n.root = {s.root[RtW-2:0], 1'b0};
    end
    return n;
  endfunction

  logic [Nst-1:0]          vld_q;
  lane_t                   a_q    [Nst];
  lane_t                   b_q    [Nst];
  tcpk_pkg::tcpk_sq_side_t side_q [Nst];

  for (genvar k = 0; k < Nst; k++) begin : g_st
    logic                    vld_in;
    lane_t                   a_in;
    lane_t                   b_in;
    tcpk_pkg::tcpk_sq_side_t side_in;

    if (k == 0) begin : g_first
      assign vld_in  = valid_i;
      assign a_in    = '{rad: {{(RadW - tcpk_pkg::SqBits){1'b0}}, rad_a_i}, rem: '0, root: '0};
      assign b_in    = '{rad: {{(RadW - tcpk_pkg::SqBits){1'b0}}, rad_b_i}, rem: '0, root: '0};
      assign side_in = side_i;
    end else begin : g_next
      assign vld_in  = vld_q[k-1];
      assign a_in    = a_q[k-1];
      assign b_in    = b_q[k-1];
      assign side_in = side_q[k-1];
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[k] <= 1'b0;
      end else begin
        vld_q[k] <= vld_in;
      end
    end

    always_ff @(posedge clk_i) begin
      a_q[k]    <= sq_step(a_in);
      b_q[k]    <= sq_step(b_in);
      side_q[k] <= side_in;
    end
  end

  assign valid_o  = vld_q[Nst-1];
  assign root_a_o = a_q[Nst-1].root;
  assign root_b_o = b_q[Nst-1].root;
  assign side_o   = side_q[Nst-1];

endmodule

// ===== design/two_cable_plotter_kinematics_unit.sv =====
// Channel    | Ports                                              | Handshake
// -----------+----------------------------------------------------+---------------------------
// command    | operation_i pos_x_i pos_y_i left_len_i right_len_i | start_i high, busy_o low
// result     | out_x_o out_y_o out_left_len_o out_right_len_o     | done_o, one cycle, no stall
//            | unreachable_o                                      |
// spacing    | spacing_i                                          | spacing_we_i
//
// One beat enters every cycle; busy_o is always low.
// Each result passes the front stages, the 43-stage divider, the middle
// stages, the 22-stage square root and the output register in turn.
// Reset clears only the valid bits and restores the spacing register.
// The receiver cannot stall, so the pipeline never holds.
module two_cable_plotter_kinematics_unit (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                start_i,
  output logic                                busy_o,
  input  logic                                operation_i,
  input  logic signed [tcpk_pkg::CoordBits-1:0] pos_x_i,
  input  logic signed [tcpk_pkg::CoordBits-1:0] pos_y_i,
  input  logic [tcpk_pkg::CoordBits-1:0]      left_len_i,
  input  logic [tcpk_pkg::CoordBits-1:0]      right_len_i,
  input  logic                                spacing_we_i,
  input  logic [tcpk_pkg::SpacingBits-1:0]    spacing_i,
  output logic                                done_o,
  output logic signed [tcpk_pkg::OutBits-1:0] out_x_o,
  output logic signed [tcpk_pkg::OutBits-1:0] out_y_o,
  output logic [tcpk_pkg::OutBits-1:0]        out_left_len_o,
  output logic [tcpk_pkg::OutBits-1:0]        out_right_len_o,
  output logic                                unreachable_o
);

  localparam int unsigned CW = tcpk_pkg::CoordBits;
  localparam int unsigned OW = tcpk_pkg::OutBits;
  localparam int unsigned SW = tcpk_pkg::SpacingBits;
  localparam int unsigned PW = tcpk_pkg::ProdBits;
  localparam int unsigned QW = tcpk_pkg::SqBits;
  localparam logic [QW-1:0] SmaxQ = QW'((64'd1 << (OW - 1)) - 64'd1);
  localparam logic [QW-1:0] SminQ = QW'(64'd1 << (OW - 1));

  logic [SW-1:0] spacing_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      spacing_q <= tcpk_pkg::SpacingReset;
    end else if (spacing_we_i) begin
      spacing_q <= spacing_i;
    end
  end

  assign busy_o = 1'b0;

  logic accept;
  assign accept = start_i && !busy_o;

  // ---- stage 1: magnitudes and multiplicands ----
  logic          nx, ny;
  logic [CW-1:0] ax, ay, dz, dx;
  logic          in_zero, in_mid;

  assign nx = pos_x_i[CW-1];
  assign ny = pos_y_i[CW-1];
  assign ax = nx ? (~$unsigned(pos_x_i) + CW'(1)) : $unsigned(pos_x_i);
  assign ay = ny ? (~$unsigned(pos_y_i) + CW'(1)) : $unsigned(pos_y_i);
  assign dz = {1'b0, spacing_q};
  // offset from the right pivot
  assign dx = nx ? (ax + dz) : ((ax >= dz) ? (ax - dz) : (dz - ax));

  assign in_zero = (spacing_q == '0);
  assign in_mid  = !spacing_q[0] && (left_len_i == {2'b00, spacing_q[SW-1:1]})
                   && (right_len_i == {2'b00, spacing_q[SW-1:1]});

  logic               s1_vld_q;
  tcpk_pkg::tcpk_op_e s1_op_q;
  logic [CW-1:0]      s1_m0_q, s1_m1_q, s1_m2_q, s1_l1_q;
  logic [SW-1:0]      s1_d_q;
  logic               s1_zero_q, s1_mid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q <= 1'b0;
    end else begin
      s1_vld_q <= accept;
    end
  end

  always_ff @(posedge clk_i) begin
    s1_op_q   <= tcpk_pkg::tcpk_op_e'(operation_i);
    s1_m0_q   <= operation_i ? left_len_i  : ax;
    s1_m1_q   <= operation_i ? right_len_i : ay;
    s1_m2_q   <= operation_i ? dz          : dx;
    s1_l1_q   <= left_len_i;
    s1_d_q    <= spacing_q;
    s1_zero_q <= in_zero;
    s1_mid_q  <= in_mid;
  end

  // ---- stage 2: three squares ----
  logic [PW-1:0] sq0, sq1, sq2;
  assign sq0 = s1_m0_q * s1_m0_q;
  assign sq1 = s1_m1_q * s1_m1_q;
  assign sq2 = s1_m2_q * s1_m2_q;

  logic               s2_vld_q;
  tcpk_pkg::tcpk_op_e s2_op_q;
  logic [PW-1:0]      s2_p0_q, s2_p1_q, s2_p2_q;
  logic [CW-1:0]      s2_l1_q;
  logic [SW-1:0]      s2_d_q;
  logic               s2_zero_q, s2_mid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_vld_q <= 1'b0;
    end else begin
      s2_vld_q <= s1_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    s2_op_q   <= s1_op_q;
    s2_p0_q   <= sq0;
    s2_p1_q   <= sq1;
    s2_p2_q   <= sq2;
    s2_l1_q   <= s1_l1_q;
    s2_d_q    <= s1_d_q;
    s2_zero_q <= s1_zero_q;
    s2_mid_q  <= s1_mid_q;
  end

  // ---- stage 3: sums; forward numerator L^2 + d^2 - R^2 as a signed word ----
  logic               s3_vld_q;
  tcpk_pkg::tcpk_op_e s3_op_q;
  logic [QW:0]        s3_diff_q;
  logic [QW-1:0]      s3_ra_q, s3_rb_q;
  logic [PW-1:0]      s3_l1sq_q;
  logic [CW-1:0]      s3_l1_q;
  logic [SW-1:0]      s3_d_q;
  logic               s3_zero_q, s3_mid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s3_vld_q <= 1'b0;
    end else begin
      s3_vld_q <= s2_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    s3_op_q   <= s2_op_q;
    s3_diff_q <= {2'b00, s2_p0_q} + {2'b00, s2_p2_q} - {2'b00, s2_p1_q};
    s3_ra_q   <= {1'b0, s2_p0_q} + {1'b0, s2_p1_q};
    s3_rb_q   <= {1'b0, s2_p2_q} + {1'b0, s2_p1_q};
    s3_l1sq_q <= s2_p0_q;
    s3_l1_q   <= s2_l1_q;
    s3_d_q    <= s2_d_q;
    s3_zero_q <= s2_zero_q;
    s3_mid_q  <= s2_mid_q;
  end

  // ---- stage 4: magnitude of the numerator, divider operands ----
  logic                     s4_vld_q;
  logic [QW-1:0]            s4_num_q;
  logic [SW:0]              s4_den_q;
  tcpk_pkg::tcpk_div_side_t s4_side_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s4_vld_q <= 1'b0;
    end else begin
      s4_vld_q <= s3_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    s4_num_q       <= s3_diff_q[QW] ? QW'(~s3_diff_q + (QW+1)'(1)) : s3_diff_q[QW-1:0];
    s4_den_q       <= {s3_d_q, 1'b0};
    s4_side_q.op   <= s3_op_q;
    s4_side_q.neg  <= s3_diff_q[QW];
    s4_side_q.zero <= s3_zero_q;
    s4_side_q.mid  <= s3_mid_q;
    s4_side_q.d    <= s3_d_q;
    s4_side_q.l1   <= s3_l1_q;
    s4_side_q.l1sq <= s3_l1sq_q;
    s4_side_q.ra   <= s3_ra_q;
    s4_side_q.rb   <= s3_rb_q;
  end

  logic                     dv_vld;
  logic [QW-1:0]            dv_q;
  tcpk_pkg::tcpk_div_side_t dv_side;

  tcpk_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (s4_vld_q),
    .num_i   (s4_num_q),
    .den_i   (s4_den_q),
    .side_i  (s4_side_q),
    .valid_o (dv_vld),
    .quo_o   (dv_q),
    .side_o  (dv_side)
  );

  // ---- stage 5: saturate x, test reach, square the quotient ----
  logic          q_over, x_sat;
  logic [OW-1:0] x_mag, x_val, ox_fwd;

  assign q_over = dv_q > {{(QW - CW){1'b0}}, dv_side.l1};
  assign x_sat  = dv_side.neg ? (dv_q > SminQ) : (dv_q > SmaxQ);
  assign x_mag  = x_sat ? (dv_side.neg ? SminQ[OW-1:0] : SmaxQ[OW-1:0]) : dv_q[OW-1:0];
  assign x_val  = dv_side.neg ? (~x_mag + OW'(1)) : x_mag;
  assign ox_fwd = dv_side.zero ? '0 :
                  dv_side.mid  ? OW'(dv_side.d[SW-1:1]) : x_val;

  logic                    s5_vld_q;
  tcpk_pkg::tcpk_sq_side_t s5_side_q;
  logic [PW-1:0]           s5_qsq_q, s5_l1sq_q;
  logic [QW-1:0]           s5_ra_q, s5_rb_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s5_vld_q <= 1'b0;
    end else begin
      s5_vld_q <= dv_vld;
    end
  end

  always_ff @(posedge clk_i) begin
    s5_side_q.op   <= dv_side.op;
    s5_side_q.noy  <= dv_side.zero || dv_side.mid || q_over;
    s5_side_q.flag <= dv_side.zero || (!dv_side.mid && (q_over || x_sat));
    s5_side_q.ox   <= ox_fwd;
    // only meaningful when the quotient does not exceed L
    s5_qsq_q       <= dv_q[CW-1:0] * dv_q[CW-1:0];
    s5_l1sq_q      <= dv_side.l1sq;
    s5_ra_q        <= dv_side.ra;
    s5_rb_q        <= dv_side.rb;
  end

  // ---- stage 6: radicands ----
  logic                    s6_vld_q;
  tcpk_pkg::tcpk_sq_side_t s6_side_q;
  logic [QW-1:0]           s6_rad_a_q, s6_rad_b_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s6_vld_q <= 1'b0;
    end else begin
      s6_vld_q <= s5_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    s6_side_q <= s5_side_q;
    unique case (s5_side_q.op)
      tcpk_pkg::OP_FORWARD: begin
        s6_rad_a_q <= s5_side_q.noy ? '0 : {1'b0, s5_l1sq_q - s5_qsq_q};
        s6_rad_b_q <= '0;
      end
      default: begin
        s6_rad_a_q <= s5_ra_q;
        s6_rad_b_q <= s5_rb_q;
      end
    endcase
  end

  logic                    sr_vld;
  logic [OW-1:0]           root_a, root_b;
  tcpk_pkg::tcpk_sq_side_t sr_side;

  tcpk_sqrt u_sqrt (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .valid_i  (s6_vld_q),
    .rad_a_i  (s6_rad_a_q),
    .rad_b_i  (s6_rad_b_q),
    .side_i   (s6_side_q),
    .valid_o  (sr_vld),
    .root_a_o (root_a),
    .root_b_o (root_b),
    .side_o   (sr_side)
  );

  // ---- output register ----
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_o <= 1'b0;
    end else begin
      done_o <= sr_vld;
    end
  end

  always_ff @(posedge clk_i) begin
    unique case (sr_side.op)
      tcpk_pkg::OP_FORWARD: begin
        out_x_o         <= sr_side.ox;
        out_y_o         <= sr_side.noy ? '0 : (~root_a + OW'(1));
        out_left_len_o  <= '0;
        out_right_len_o <= '0;
        unreachable_o   <= sr_side.flag;
      end
      default: begin
        out_x_o         <= '0;
        out_y_o         <= '0;
        out_left_len_o  <= root_a;
        out_right_len_o <= root_b;
        unreachable_o   <= 1'b0;
      end
    endcase
  end

  // every accepted command comes out on done_o once it has passed the whole pipeline
  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |-> ##(tcpk_pkg::Latency) done_o)
    else $error("result missing at fixed latency");

  // the pen never sits above the motor line
  a_y_below: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> (out_y_o[OW-1] || out_y_o == '0))
    else $error("out_y above motor line");

  // a beat with cable lengths carries no position
  a_inv_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && (out_left_len_o != '0 || out_right_len_o != '0))
      |-> (out_x_o == '0 && out_y_o == '0 && !unreachable_o))
    else $error("inverse result carries position");

endmodule

// ===== verif/tb_top.sv =====
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned CoordBits   = tcpk_pkg::CoordBits;
  localparam int unsigned OutBits     = tcpk_pkg::OutBits;
  localparam int unsigned SpacingBits = tcpk_pkg::SpacingBits;
  localparam int unsigned Latency     = tcpk_pkg::Latency;

  localparam int unsigned NumRandom  = 1730;
  localparam int unsigned CycleLimit = 400000;
  localparam longint unsigned OutMask = (64'd1 << OutBits) - 1;
  localparam longint unsigned OutSmax = (64'd1 << (OutBits - 1)) - 1;

  // one computed pen/cable beat
  typedef struct packed {
    logic [OutBits-1:0] x;
    logic [OutBits-1:0] y;
    logic [OutBits-1:0] left;
    logic [OutBits-1:0] right;
    logic               unreach;
  } kin_result_t;

  typedef struct packed {
    tcpk_pkg::tcpk_op_e   op;
    logic [CoordBits-1:0] px;
    logic [CoordBits-1:0] py;
    logic [CoordBits-1:0] ll;
    logic [CoordBits-1:0] rl;
  } kin_cmd_t;

  // directed row: command plus an optional typed-in answer
  typedef struct {
    kin_cmd_t    cmd;
    logic        typed;
    kin_result_t answer;
  } kin_row_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic start_i = 1'b0;
  logic operation_i = 1'b0;
  logic signed [CoordBits-1:0] pos_x_i = '0;
  logic signed [CoordBits-1:0] pos_y_i = '0;
  logic [CoordBits-1:0] left_len_i = '0;
  logic [CoordBits-1:0] right_len_i = '0;
  logic spacing_we_i = 1'b0;
  logic [SpacingBits-1:0] spacing_i = '0;
  logic busy_o, done_o, unreachable_o;
  logic signed [OutBits-1:0] out_x_o, out_y_o;
  logic [OutBits-1:0] out_left_len_o, out_right_len_o;

  always #10 clk_i = ~clk_i;

  two_cable_plotter_kinematics_unit u_dut (
    .clk_i, .rst_ni, .start_i, .busy_o, .operation_i, .pos_x_i, .pos_y_i,
    .left_len_i, .right_len_i, .spacing_we_i, .spacing_i, .done_o, .out_x_o,
    .out_y_o, .out_left_len_o, .out_right_len_o, .unreachable_o
  );

  longint unsigned spacing_shadow;
  kin_result_t pending_results[$];
  int unsigned error_count = 0;
  int unsigned beats_sent = 0;
  int unsigned beats_seen = 0;
  int unsigned fwd_count = 0;
  int unsigned unreach_count = 0;
  longint unsigned cycle_count = 0;

  function automatic longint unsigned floor_sqrt(longint unsigned v);
    longint unsigned root, bitv;
    root = 0;
    bitv = 64'd1 << 62;
    while (bitv > v) bitv >>= 2;
    while (bitv != 0) begin
      if (v >= root + bitv) begin
        v -= root + bitv;
        root = (root >> 1) + bitv;
      end else begin
        root >>= 1;
      end
      bitv >>= 2;
    end
    return root;
  endfunction

  // Work out the beat the block must produce for one command.
  function automatic kin_result_t solve_kinematics(kin_cmd_t c, longint unsigned d);
    kin_result_t r;
    longint signed sx, sy;
    longint unsigned ax, ay, dx, l1, l2, a, b, q, sat, rt;
    logic neg;
    r = '0;
    if (c.op == tcpk_pkg::OP_INVERSE) begin
      sx = longint'(signed'(c.px));
      sy = longint'(signed'(c.py));
      ax = (sx < 0) ? -sx : sx;
      ay = (sy < 0) ? -sy : sy;
      if (sx < 0) dx = ax + d;
      else dx = (ax >= d) ? ax - d : d - ax;
      l1 = floor_sqrt(ax * ax + ay * ay);
      l2 = floor_sqrt(dx * dx + ay * ay);
      // clamp lengths past the output range
      if (l1 > OutMask) begin l1 = OutMask; r.unreach = 1'b1; end
      if (l2 > OutMask) begin l2 = OutMask; r.unreach = 1'b1; end
      r.left = l1[OutBits-1:0];
      r.right = l2[OutBits-1:0];
    end else begin
      l1 = c.ll;
      l2 = c.rl;
      if (d == 0) begin
        r.unreach = 1'b1;
      end else if (d[0] == 1'b0 && l1 == (d >> 1) && l2 == (d >> 1)) begin
        r.x = OutBits'(d >> 1);
      end else begin
        a = l1 * l1 + d * d;
        b = l2 * l2;
        neg = a < b;
        q = (neg ? b - a : a - b) / (d * 2);
        if (neg) begin
          sat = q;
          if (q > OutSmax + 1) begin sat = OutSmax + 1; r.unreach = 1'b1; end
          r.x = OutBits'(-sat);
        end else begin
          sat = q;
          if (q > OutSmax) begin sat = OutSmax; r.unreach = 1'b1; end
          r.x = OutBits'(sat);
        end
        // negative radicand drops y to the motor line
        if (q > l1) begin
          r.unreach = 1'b1;
        end else begin
          rt = floor_sqrt(l1 * l1 - q * q);
          if (rt > OutSmax + 1) begin rt = OutSmax + 1; r.unreach = 1'b1; end
          r.y = OutBits'(-rt);
        end
      end
    end
    return r;
  endfunction

  task automatic report_mismatch(string what, longint unsigned got, longint unsigned want);
    $display("MISMATCH beat %0d %s: got %0h expected %0h", beats_seen, what, got, want);
    error_count++;
  endtask

  // Drive one command beat; hold it until accepted.
  task automatic send_cmd(kin_cmd_t c, bit gaps);
    int unsigned idle;
    if (gaps && $urandom_range(0, 3) == 0) begin
      start_i <= 1'b0;
      idle = $urandom_range(1, 16);
      repeat (idle) @(negedge clk_i);
    end
    start_i <= 1'b1;
    operation_i <= c.op;
    pos_x_i <= c.px;
    pos_y_i <= c.py;
    left_len_i <= c.ll;
    right_len_i <= c.rl;
    do @(posedge clk_i); while (busy_o);
    pending_results.push_back(solve_kinematics(c, spacing_shadow));
    beats_sent++;
    if (c.op == tcpk_pkg::OP_FORWARD) fwd_count++;
    @(negedge clk_i);
  endtask

  // Let the pipeline drain, then write the spacing register.
  task automatic load_spacing(longint unsigned value);
    start_i <= 1'b0;
    while (pending_results.size() != 0) @(negedge clk_i);
    repeat (Latency + 4) @(negedge clk_i);
    spacing_we_i <= 1'b1;
    spacing_i <= value[SpacingBits-1:0];
    @(negedge clk_i);
    spacing_we_i <= 1'b0;
    spacing_shadow = value & ((64'd1 << SpacingBits) - 1);
  endtask

  function automatic kin_cmd_t random_cmd(longint unsigned d);
    kin_cmd_t c;
    longint unsigned lsum;
    int unsigned sel;
    c.op = tcpk_pkg::tcpk_op_e'($urandom_range(0, 1));
    c.px = CoordBits'($urandom);
    c.py = CoordBits'($urandom);
    c.ll = CoordBits'($urandom);
    c.rl = CoordBits'($urandom);
    sel = $urandom_range(0, 9);
    if (c.op == tcpk_pkg::OP_FORWARD && sel < 6) begin
      // mostly reachable triangles: lengths near each other and the span
      c.ll = CoordBits'($urandom_range(0, 32'(2 * d + 1000)));
      lsum = c.ll + d;
      c.rl = CoordBits'((c.ll > d ? c.ll - d : d - c.ll) +
                        $urandom_range(0, 32'(lsum - (c.ll > d ? c.ll - d : d - c.ll))));
    end else if (c.op == tcpk_pkg::OP_INVERSE && sel < 5) begin
      c.px = CoordBits'($urandom_range(0, 32'(d + 1)));
      c.py = -CoordBits'($urandom_range(0, 300000));
    end
    return c;
  endfunction

  // Sample result beats; the receiver never stalls.
  always @(posedge clk_i) begin
    kin_result_t want;
    if (rst_ni) begin
      cycle_count++;
      if (cycle_count > CycleLimit) begin
        $display("Timeout after %0d cycles", cycle_count);
        $display("Regression FAIL");
        $finish;
      end
      if (done_o) begin
        beats_seen++;
        if (pending_results.size() == 0) begin
          $display("Unexpected result beat %0d", beats_seen);
          error_count++;
        end else begin
          want = pending_results.pop_front();
          if (unreachable_o) unreach_count++;
          if (out_x_o !== want.x) report_mismatch("out_x", out_x_o, want.x);
          if (out_y_o !== want.y) report_mismatch("out_y", out_y_o, want.y);
          if (out_left_len_o !== want.left)
            report_mismatch("out_left_len", out_left_len_o, want.left);
          if (out_right_len_o !== want.right)
            report_mismatch("out_right_len", out_right_len_o, want.right);
          if (unreachable_o !== want.unreach)
            report_mismatch("unreachable", unreachable_o, want.unreach);
        end
      end
    end
  end

  initial begin
    kin_row_t rows[$];
    kin_row_t row;
    kin_result_t fresh;
    longint unsigned spans[5];
    int unsigned phase_len;
    spacing_shadow = tcpk_pkg::SpacingReset;
    spans = '{64'd1, 64'd1048575, 64'd1000, 64'd77777, 64'd256000};

    // Directed rows at the reset spacing (d = 256000).
    fresh = '0;
    row.typed = 1'b1;
    row.cmd = '{tcpk_pkg::OP_INVERSE, '0, '0, '0, '0};
    row.answer = '{'0, '0, '0, OutBits'(256000), 1'b0};
    rows.push_back(row);
    row.cmd = '{tcpk_pkg::OP_FORWARD, '0, '0, CoordBits'(128000), CoordBits'(128000)};
    row.answer = '{OutBits'(128000), '0, '0, '0, 1'b0};
    rows.push_back(row);
    row.cmd = '{tcpk_pkg::OP_INVERSE, CoordBits'(256000), '0, '0, '0};
    row.answer = '{'0, '0, OutBits'(256000), '0, 1'b0};
    rows.push_back(row);
    row.typed = 1'b0;
    row.answer = fresh;
    row.cmd = '{tcpk_pkg::OP_INVERSE, {1'b0, {20{1'b1}}}, {1'b0, {20{1'b1}}}, '0, '0};
    rows.push_back(row);
    row.cmd = '{tcpk_pkg::OP_INVERSE, {1'b1, 20'd0}, {1'b1, 20'd0}, '1, '1};
    rows.push_back(row);
    row.cmd = '{tcpk_pkg::OP_INVERSE, {1'b1, 20'd0}, {1'b0, {20{1'b1}}}, '0, '0};
    rows.push_back(row);
    row.cmd = '{tcpk_pkg::OP_INVERSE, '1, '1, '0, '0};
    rows.push_back(row);
    row.cmd = '{tcpk_pkg::OP_FORWARD, '0, '0, '1, '1};
    rows.push_back(row);
    row.cmd = '{tcpk_pkg::OP_FORWARD, '1, '1, '1, '0};
    rows.push_back(row);
    row.cmd = '{tcpk_pkg::OP_FORWARD, '0, '0, '0, '1};
    rows.push_back(row);
    row.cmd = '{tcpk_pkg::OP_FORWARD, '0, '0, CoordBits'(10), CoordBits'(10)};
    rows.push_back(row);
    row.cmd = '{tcpk_pkg::OP_FORWARD, '0, '0, CoordBits'(200000), CoordBits'(200000)};
    rows.push_back(row);
    row.cmd = '{tcpk_pkg::OP_FORWARD, '0, '0, CoordBits'(128000), CoordBits'(128001)};
    rows.push_back(row);
    row.cmd = '{tcpk_pkg::OP_FORWARD, '0, '0, '0, '0};
    rows.push_back(row);

    repeat (11) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    foreach (rows[i]) begin
      if (rows[i].typed && solve_kinematics(rows[i].cmd, spacing_shadow) !== rows[i].answer)
        $display("Row %0d: predictor disagrees with typed answer", i);
      send_cmd(rows[i].cmd, 1'b0);
      if (rows[i].typed) pending_results[$] = rows[i].answer;
    end

    // Zero spacing: forward flags, inverse computes with d = 0.
    load_spacing(0);
    send_cmd('{tcpk_pkg::OP_FORWARD, '0, '0, CoordBits'(5), CoordBits'(7)}, 1'b0);
    pending_results[$] = '{'0, '0, '0, '0, 1'b1};
    send_cmd('{tcpk_pkg::OP_INVERSE, CoordBits'(-3), CoordBits'(4), '0, '0}, 1'b0);

    // Random phases across several spacings, ending with a gap-free stream.
    foreach (spans[p]) begin
      load_spacing(spans[p]);
      send_cmd('{tcpk_pkg::OP_FORWARD, '0, '0, CoordBits'(spans[p] >> 1),
                 CoordBits'(spans[p] >> 1)}, 1'b0);
      phase_len = NumRandom / 5;
      for (int unsigned n = 0; n < phase_len; n++)
        send_cmd(random_cmd(spacing_shadow), p != 4);
    end
    start_i <= 1'b0;

    while (pending_results.size() != 0) @(negedge clk_i);
    repeat (Latency + 8) @(negedge clk_i);

    $display("Sent %0d beats (%0d forward) over 6 spacings incl. 0 and both extremes",
             beats_sent, fwd_count);
    $display("Checked %0d result beats, %0d flagged unreachable", beats_seen, unreach_count);
    if (error_count == 0 && pending_results.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
